// ----- rtl/core/pbfq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Per-bank FIFO request queue package
// Sizes, codes and transfer types shared by the request queue and its testbench.
// ----------------------------------------------------------------------------
package pbfq_pkg;

   // Bank count and queue depth are powers of two.
   localparam int BANKS       = 16;
   localparam int QUEUE_DEPTH = 8;
   localparam int ROW_BITS    = 16;
   localparam int TAG_BITS    = 8;

   localparam int BANK_BITS   = $clog2(BANKS);
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_BITS  = TAG_BITS + ROW_BITS;
   localparam int SLOTS       = BANKS * QUEUE_DEPTH;

   localparam logic [1:0] OP_STORE  = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]          op;
      logic [3:0]          bank_select;
      logic [TAG_BITS-1:0] request_tag;
      logic [ROW_BITS-1:0] request_row;
      logic [ROW_BITS-1:0] query_row;
   } req_type;

   typedef struct packed {
      logic                  head_valid;
      logic [TAG_BITS-1:0]   head_tag;
      logic [ROW_BITS-1:0]   head_row;
      logic                  further_request;
      logic                  further_row_hit;
      logic [COUNT_BITS-1:0] bank_occupancy;
      logic [1:0]            status;
   } rsp_type;

   typedef struct packed {
      logic                  head_valid;
      logic                  further_request;
      logic [COUNT_BITS-1:0] bank_occupancy;
      logic [1:0]            status;
      logic                  head_new;
      logic                  second_new;
   } stage_type;

endpackage
`default_nettype wire

// ----- rtl/core/per_bank_fifo_request_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Per-bank FIFO request queue
// One first-in first-out queue of tagged row requests for each DRAM bank.
// ----------------------------------------------------------------------------
// The block accepts one transfer per clock while the result side does not
// stall, and returns exactly one result per transfer through the middle stage
// and the result register. Per-bank head pointers and counts sit in
// flip-flops, so back-to-back transfers to the same bank see each other's
// effects at once. The queued requests live in a RAM with one write port and
// two registered read ports; the head and the second entry are read in the
// acceptance cycle, and a request stored in that same cycle is forwarded
// around the RAM. No clearing pass is needed after reset.
module per_bank_fifo_request_queue
   import pbfq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int ADDR_BITS = BANK_BITS + PTR_BITS;

   logic [COUNT_BITS-1:0] count_ff [BANKS];
   logic [COUNT_BITS-1:0] count_in [BANKS];
   logic [PTR_BITS-1:0]   head_ff  [BANKS];
   logic [PTR_BITS-1:0]   head_in  [BANKS];

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   stage_type             s1_meta_ff;
   stage_type             s1_meta_in;
   logic [ROW_BITS-1:0]   s1_query_row_ff;
   logic [ENTRY_BITS-1:0] s1_wr_data_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_data_ff;
   rsp_type               rsp_data_in;

   logic                  accept;
   logic                  s1_move;
   logic [BANK_BITS-1:0]  bank;
   logic [COUNT_BITS-1:0] cnt;
   logic [PTR_BITS-1:0]   hp;
   logic                  store_ok;
   logic                  remove_ok;
   logic [COUNT_BITS-1:0] new_cnt;
   logic [PTR_BITS-1:0]   new_hp;
   logic [PTR_BITS-1:0]   wr_ptr;
   logic [PTR_BITS-1:0]   second_ptr;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [ADDR_BITS-1:0]  head_addr;
   logic [ADDR_BITS-1:0]  second_addr;
   logic [ENTRY_BITS-1:0] wr_data;
   logic [ENTRY_BITS-1:0] head_entry;
   logic [ENTRY_BITS-1:0] second_entry;
   logic [ENTRY_BITS-1:0] ram_head;
   logic [ENTRY_BITS-1:0] ram_second;

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   assign bank = req_data.bank_select[BANK_BITS-1:0];
   assign cnt  = count_ff[bank];
   assign hp   = head_ff[bank];

   always_comb begin
      store_ok  = 1'b0;
      remove_ok = 1'b0;
      s1_meta_in.status = ST_OK;
      case (req_data.op)
         OP_STORE: begin
            if (cnt == COUNT_BITS'(QUEUE_DEPTH)) begin
               s1_meta_in.status = ST_FULL;
            end else begin
               store_ok = 1'b1;
            end
         end
         OP_REMOVE: begin
            if (cnt == '0) begin
               s1_meta_in.status = ST_EMPTY;
            end else begin
               remove_ok = 1'b1;
            end
         end
         OP_QUERY: begin
            s1_meta_in.status = ST_OK;
         end
         default: begin
            s1_meta_in.status = ST_OK;
         end
      endcase

      if (store_ok) begin
         new_cnt = COUNT_BITS'(cnt + 1'b1);
      end else if (remove_ok) begin
         new_cnt = COUNT_BITS'(cnt - 1'b1);
      end else begin
         new_cnt = cnt;
      end
      new_hp     = remove_ok ? PTR_BITS'(hp + 1'b1) : hp;
      second_ptr = PTR_BITS'(new_hp + 1'b1);
      wr_ptr     = PTR_BITS'(hp + cnt[PTR_BITS-1:0]);

      wr_addr     = {bank, wr_ptr};
      head_addr   = {bank, new_hp};
      second_addr = {bank, second_ptr};
      wr_data     = {req_data.request_tag, req_data.request_row};

      s1_meta_in.head_valid      = new_cnt != '0;
      s1_meta_in.further_request = new_cnt > COUNT_BITS'(1);
      s1_meta_in.bank_occupancy  = new_cnt;
      s1_meta_in.head_new        = store_ok && (wr_addr == head_addr);
      s1_meta_in.second_new      = store_ok && (wr_addr == second_addr);
   end

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      if (accept) begin
         count_in[bank] = new_cnt;
         head_in[bank]  = new_hp;
      end
   end

   pbfq_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (SLOTS)
   ) u_store (
      .clock     (clock),
      .wr_en     (accept && store_ok),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (accept),
      .rd_addr_a (head_addr),
      .rd_addr_b (second_addr),
      .rd_data_a (ram_head),
      .rd_data_b (ram_second)
   );

   assign s1_valid_in  = accept || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_ready);

   assign head_entry   = s1_meta_ff.head_new ? s1_wr_data_ff : ram_head;
   assign second_entry = s1_meta_ff.second_new ? s1_wr_data_ff : ram_second;

   always_comb begin
      rsp_data_in.head_valid      = s1_meta_ff.head_valid;
      rsp_data_in.head_tag        = '0;
      rsp_data_in.head_row        = '0;
      if (s1_meta_ff.head_valid) begin
         rsp_data_in.head_tag = head_entry[ENTRY_BITS-1:ROW_BITS];
         rsp_data_in.head_row = head_entry[ROW_BITS-1:0];
      end
      rsp_data_in.further_request = s1_meta_ff.further_request;
      rsp_data_in.further_row_hit = s1_meta_ff.further_request
                                    && (second_entry[ROW_BITS-1:0] == s1_query_row_ff);
      rsp_data_in.bank_occupancy  = s1_meta_ff.bank_occupancy;
      rsp_data_in.status          = s1_meta_ff.status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BANKS; i++) begin
            count_ff[i] <= '0;
            head_ff[i]  <= '0;
         end
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         head_ff      <= head_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff      <= s1_meta_in;
         s1_query_row_ff <= req_data.query_row;
         s1_wr_data_ff   <= wr_data;
      end
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A transfer is only taken when the middle stage is free or moving on.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted transfer did not reach the middle stage");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.head_valid == (rsp_data.bank_occupancy != '0)))
      else $error("head valid disagrees with occupancy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.bank_occupancy <= COUNT_BITS'(QUEUE_DEPTH)))
      else $error("occupancy above queue depth");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_FULL)
      |-> (rsp_data.bank_occupancy == COUNT_BITS'(QUEUE_DEPTH)))
      else $error("dropped store reported on a bank that is not full");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.further_row_hit) |-> rsp_data.further_request)
      else $error("row hit reported without a second request");

endmodule
`default_nettype wire

// ----- rtl/core/pbfq_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Request queue storage
// Generic RAM with one write port and two read ports with registered data.
// ----------------------------------------------------------------------------
module pbfq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule
`default_nettype wire

// ----- bench/per_bank_fifo_request_queue_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Per-bank FIFO request queue testbench
// Drives store, remove and query transfers with random gaps and stalls into the
// per-bank request queue and compares every report against a bank model.
// ----------------------------------------------------------------------------
module per_bank_fifo_request_queue_test;
   import pbfq_pkg::*;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         LONG_HOLD    = 300;
   localparam int         DRAIN_WAIT   = 20;
   localparam int         RANDOM_RUNS  = 17;
   localparam int         RUN_LENGTH   = 100;
   localparam int         EXPECT_DEPTH = 4096;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   bit [TAG_BITS-1:0] bank_tags [BANKS][QUEUE_DEPTH];
   bit [ROW_BITS-1:0] bank_rows [BANKS][QUEUE_DEPTH];
   int unsigned       bank_head [BANKS];
   int unsigned       bank_count [BANKS];

   rsp_type     expected_reports [EXPECT_DEPTH];
   int unsigned expected_wr = 0;
   int unsigned expected_rd = 0;
   int          mismatch_count = 0;
   bit          idle_enable = 1'b1;
   bit          long_hold_request = 1'b0;

   per_bank_fifo_request_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic rsp_type predict_bank_report(req_type item);
      int unsigned bank;
      int unsigned slot;
      rsp_type     report;
      bank = 32'(item.bank_select) % BANKS;
      report = '0;
      report.status = ST_OK;
      if (item.op == OP_STORE) begin
         if (bank_count[bank] >= QUEUE_DEPTH) begin
            report.status = ST_FULL;
         end else begin
            slot = (bank_head[bank] + bank_count[bank]) % QUEUE_DEPTH;
            bank_tags[bank][slot] = item.request_tag;
            bank_rows[bank][slot] = item.request_row;
            bank_count[bank]++;
         end
      end else if (item.op == OP_REMOVE) begin
         if (bank_count[bank] == 0) begin
            report.status = ST_EMPTY;
         end else begin
            bank_head[bank] = (bank_head[bank] + 1) % QUEUE_DEPTH;
            bank_count[bank]--;
         end
      end
      if (bank_count[bank] >= 1) begin
         report.head_valid = 1'b1;
         report.head_tag   = bank_tags[bank][bank_head[bank]];
         report.head_row   = bank_rows[bank][bank_head[bank]];
      end
      if (bank_count[bank] >= 2) begin
         report.further_request = 1'b1;
         slot = (bank_head[bank] + 1) % QUEUE_DEPTH;
         report.further_row_hit = (bank_rows[bank][slot] == item.query_row);
      end
      report.bank_occupancy = COUNT_BITS'(bank_count[bank]);
      return report;
   endfunction

   // Row of the entry that will sit second in the bank once the operation is done.
   function automatic logic [ROW_BITS-1:0] upcoming_second_row(int unsigned bank,
                                                               logic [1:0] op);
      int unsigned offset;
      offset = (op == OP_REMOVE) ? 2 : 1;
      return bank_rows[bank][(bank_head[bank] + offset) % QUEUE_DEPTH];
   endfunction

   function automatic int next_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (!idle_enable || pick < 60) begin
         return 0;
      end else if (pick < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic req_type random_request(int store_pct, int remove_pct,
                                              int unsigned focus_bank);
      req_type     item;
      int          pick;
      int unsigned bank;
      item = '0;
      pick = $urandom_range(0, 99);
      if (pick < store_pct) begin
         item.op = OP_STORE;
      end else if (pick < store_pct + remove_pct) begin
         item.op = OP_REMOVE;
      end else begin
         item.op = ($urandom_range(0, 3) == 0) ? OP_UNUSED : OP_QUERY;
      end
      if ($urandom_range(0, 1) == 0) begin
         item.bank_select = 4'(focus_bank + $urandom_range(0, 1));
      end else begin
         item.bank_select = 4'($urandom_range(0, 15));
      end
      bank = 32'(item.bank_select) % BANKS;
      item.request_tag = 8'($urandom);
      item.request_row = 16'($urandom);
      if ($urandom_range(0, 9) < 4 && bank_count[bank] >= 2) begin
         item.query_row = upcoming_second_row(bank, item.op);
      end else if ($urandom_range(0, 9) == 0) begin
         item.query_row = item.request_row;
      end else begin
         item.query_row = 16'($urandom);
      end
      return item;
   endfunction

   task automatic send_request(input req_type item);
      int gap;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      expected_reports[expected_wr % EXPECT_DEPTH] = predict_bank_report(item);
      expected_wr++;
      gap = next_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic report_mismatch(input string message);
      $display("%0t ns: %s", $time, message);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] actual,
                              input logic [31:0] wanted);
      if (actual !== wanted) begin
         report_mismatch($sformatf("%s is %0h, expected %0h", name, actual, wanted));
      end
   endtask

   initial begin
      forever begin : result_check
         rsp_type wanted;
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_rd == expected_wr) begin
               report_mismatch("result transfer with no request waiting for it");
            end else begin
               wanted = expected_reports[expected_rd % EXPECT_DEPTH];
               expected_rd++;
               check_field("head_valid", 32'(rsp_data.head_valid),
                           32'(wanted.head_valid));
               check_field("head_tag", 32'(rsp_data.head_tag), 32'(wanted.head_tag));
               check_field("head_row", 32'(rsp_data.head_row), 32'(wanted.head_row));
               check_field("further_request", 32'(rsp_data.further_request),
                           32'(wanted.further_request));
               check_field("further_row_hit", 32'(rsp_data.further_row_hit),
                           32'(wanted.further_row_hit));
               check_field("bank_occupancy", 32'(rsp_data.bank_occupancy),
                           32'(wanted.bank_occupancy));
               check_field("status", 32'(rsp_data.status), 32'(wanted.status));
            end
         end
      end
   end

   initial begin
      forever begin : result_receiver
         int gap;
         @(posedge clock);
         if (long_hold_request) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(posedge clock);
            long_hold_request = 1'b0;
         end else begin
            gap = next_gap();
            if (gap == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               repeat (gap - 1) @(posedge clock);
            end
         end
      end
   end

   task automatic test_empty_bank_and_unused_op();
      send_request(req_type'{OP_REMOVE, 4'd0, 8'hff, 16'hffff, 16'hffff});
      send_request(req_type'{OP_UNUSED, 4'd0, 8'h00, 16'h0000, 16'h0000});
   endtask

   task automatic test_fill_overflow_drain();
      logic [ROW_BITS-1:0] rows [QUEUE_DEPTH];
      req_type             item;
      idle_enable = 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         rows[i] = (i == 0) ? 16'hffff : (i == 1) ? 16'h0000 : 16'($urandom);
         item = req_type'{OP_STORE, 4'd15, 8'($urandom), rows[i], 16'($urandom)};
         if (i == 0) item.request_tag = 8'hff;
         if (i == 1) item.request_tag = 8'h00;
         send_request(item);
      end
      send_request(req_type'{OP_STORE, 4'd15, 8'h5a, 16'h1234, 16'h0000});
      send_request(req_type'{OP_QUERY, 4'd15, 8'h00, 16'h0000, rows[1]});
      send_request(req_type'{OP_QUERY, 4'd15, 8'h00, 16'h0000, 16'hffff});
      idle_enable = 1'b1;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         item = req_type'{OP_REMOVE, 4'd15, 8'h00, 16'h0000, 16'($urandom)};
         if (i + 2 < QUEUE_DEPTH && i % 2 == 0) item.query_row = rows[i + 2];
         send_request(item);
      end
      send_request(req_type'{OP_REMOVE, 4'd15, 8'h00, 16'h0000, 16'h0000});
   endtask

   task automatic test_output_stall_backpressure();
      long_hold_request = 1'b1;
      idle_enable = 1'b0;
      for (int i = 0; i < 60; i++) begin
         send_request(random_request(50, 30, 4));
      end
      idle_enable = 1'b1;
   endtask

   task automatic test_random_traffic();
      int unsigned focus_bank;
      for (int run = 0; run < RANDOM_RUNS; run++) begin
         idle_enable = (run % 4 != 3);
         focus_bank = $urandom_range(0, 14);
         for (int i = 0; i < RUN_LENGTH; i++) begin
            if (run % 2 == 0) begin
               send_request(random_request(55, 25, focus_bank));
            end else begin
               send_request(random_request(25, 55, focus_bank));
            end
         end
      end
      idle_enable = 1'b1;
   endtask

   initial begin
      for (int b = 0; b < BANKS; b++) begin
         bank_head[b]  = 0;
         bank_count[b] = 0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_bank_and_unused_op();
      test_fill_overflow_drain();
      test_output_stall_backpressure();
      test_random_traffic();
      req_valid <= 1'b0;
      while (expected_rd != expected_wr) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
